[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the averager's checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define BVA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked during reset.
`define BVA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/bva_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bva_pkg
// Types and constants shared by the battery voltage averager files.
// ----------------------------------------------------------------------------
package bva_pkg;

   localparam int DATA_W = 16;
   localparam int PCT_W  = 7;

   localparam logic [DATA_W-1:0] THRESHOLD_RESET = 16'd1900;
   localparam logic [DATA_W-1:0] PCT_LOW_MV      = 16'd2000;
   localparam logic [DATA_W-1:0] PCT_HIGH_MV     = 16'd3000;
   localparam logic [PCT_W-1:0]  PCT_FULL        = 7'd100;

   // Division by ten of a value below 1024 as (x * 205) >> 11.
   localparam int PCT_DIFF_W  = 10;
   localparam int RECIP_W     = 8;
   localparam int PCT_PROD_W  = PCT_DIFF_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_TEN = 8'd205;
   localparam int RECIP_SHIFT = 11;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_ADD   = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_PCT   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   typedef struct packed {
      logic load;        // capture the accepted reading
      logic mark_low;    // record the low battery flag for the result
      logic accumulate;  // add reading to sum and count, start divider
      logic div_step;    // one quotient bit
      logic finish;      // percentage and halving decay
      logic emit;        // load the output register
   } cmd_type;

   typedef struct packed {
      logic reading_zero;
      logic reading_low;
      logic div_last;
   } status_type;

endpackage
`default_nettype wire

[hdl/bva_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bva interfaces
// Valid/ready channels for readings, results and the threshold register.
// ----------------------------------------------------------------------------
interface bva_req_if;
   import bva_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] reading_mv;
   modport source (output valid, output reading_mv, input ready);
   modport sink   (input valid, input reading_mv, output ready);
endinterface

interface bva_rsp_if;
   import bva_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] average_mv;
   logic [PCT_W-1:0]  percent;
   logic              low_battery;
   modport source (output valid, output average_mv, output percent, output low_battery,
                   input ready);
   modport sink   (input valid, input average_mv, input percent, input low_battery,
                   output ready);
endinterface

interface bva_csr_if;
   import bva_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] low_threshold_mv;
   modport source (output valid, output low_threshold_mv, input ready);
   modport sink   (input valid, input low_threshold_mv, output ready);
endinterface
`default_nettype wire

[hdl/bva_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bva_ctrl
// Sequencer for one reading: check, accumulate, divide, scale, emit.
// ----------------------------------------------------------------------------
module bva_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  bva_pkg::status_type status,
   output bva_pkg::cmd_type    cmd
);
   import bva_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.load       = (state_ff == ST_IDLE) && req_valid;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.mark_low = 1'b1;
            if (status.reading_zero) begin
               state_in = ST_IDLE;
            end else if (status.reading_low) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.accumulate = 1'b1;
            state_in       = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_PCT;
         end
         ST_PCT: begin
            cmd.finish = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

[hdl/bva_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bva_datapath
// Threshold register, running sum and count, serial divider, percent scaler
// and the result register.
// ----------------------------------------------------------------------------
module bva_datapath #(
   parameter int AVERAGE_LIMIT = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [bva_pkg::DATA_W-1:0]    csr_data,
   input  logic [bva_pkg::DATA_W-1:0]    reading_mv,
   input  bva_pkg::cmd_type              cmd,
   output bva_pkg::status_type           status,
   output logic [bva_pkg::DATA_W-1:0]    average_mv,
   output logic [bva_pkg::PCT_W-1:0]     percent,
   output logic                          low_battery
);
   import bva_pkg::*;

   localparam int SUM_W   = DATA_W + $clog2(AVERAGE_LIMIT);
   localparam int COUNT_W = $clog2(AVERAGE_LIMIT + 1);
   localparam int STEP_W  = $clog2(SUM_W + 1);

   logic [DATA_W-1:0]  threshold_ff;
   logic [DATA_W-1:0]  reading_ff;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [PCT_W-1:0]   pct_ff, pct_in;
   logic               low_ff;
   logic [DATA_W-1:0]  average_ff;
   logic [PCT_W-1:0]   percent_ff;
   logic               low_out_ff;

   logic [COUNT_W:0]   shifted;
   logic [COUNT_W+1:0] trial;
   logic [DATA_W-1:0]  avg;
   logic [DATA_W-1:0]  diff;
   logic [PCT_PROD_W-1:0] prod;

   assign status.reading_zero = (reading_ff == '0);
   assign status.reading_low  = (reading_ff < threshold_ff);
   assign status.div_last     = (step_ff == STEP_W'(1));

   // Restoring division: one quotient bit per step, remainder below the count.
   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, count_ff};

   assign avg  = quo_ff[DATA_W-1:0];
   assign diff = avg - PCT_LOW_MV;
   assign prod = diff[PCT_DIFF_W-1:0] * RECIP_TEN;

   always_comb begin
      if (avg >= PCT_HIGH_MV) begin
         pct_in = PCT_FULL;
      end else if (avg > PCT_LOW_MV) begin
         pct_in = prod[RECIP_SHIFT +: PCT_W];
      end else begin
         pct_in = '0;
      end
   end

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      if (cmd.accumulate) begin
         sum_in   = sum_ff + SUM_W'(reading_ff);
         count_in = count_ff + COUNT_W'(1);
         quo_in   = sum_in;
         rem_in   = '0;
         step_in  = STEP_W'(SUM_W);
      end else if (cmd.div_step) begin
         step_in = step_ff - STEP_W'(1);
         if (!trial[COUNT_W+1]) begin
            rem_in = trial[COUNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[COUNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
      end else if (cmd.finish) begin
         if (count_ff >= COUNT_W'(AVERAGE_LIMIT)) begin
            sum_in   = sum_ff >> 1;
            count_in = count_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         sum_ff       <= '0;
         count_ff     <= '0;
         step_ff      <= '0;
      end else begin
         if (csr_write) threshold_ff <= csr_data;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.load)     reading_ff <= reading_mv;
      if (cmd.mark_low) low_ff     <= status.reading_low;
      if (cmd.finish)   pct_ff     <= pct_in;
      if (cmd.emit) begin
         average_ff <= low_ff ? '0 : avg;
         percent_ff <= low_ff ? '0 : pct_ff;
         low_out_ff <= low_ff;
      end
   end

   assign average_mv  = average_ff;
   assign percent     = percent_ff;
   assign low_battery = low_out_ff;

endmodule
`default_nettype wire

[hdl/battery_voltage_averager.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// battery_voltage_averager
// Running average of battery readings with halving decay and charge percent.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                      Notes
//   req_chan  in         reading_mv[15:0]                             zero = no reading
//   rsp_chan  out        average_mv[15:0], percent[6:0], low_battery  one per reading at most
//   csr_chan  in         low_threshold_mv[15:0]                       always ready
//
// A normal reading passes from its transfer through CHECK, ADD, DIV, PCT and
// EMIT before the block is ready again; it stays in DIV while the restoring
// divider produces one quotient bit per cycle. A low reading passes through
// CHECK and EMIT, a zero reading through CHECK alone. Reset is synchronous and
// active high; it clears the sum, the count and the result valid flag, and
// loads the threshold with 1900 mV. A finished result sits in the output
// register while the next reading is taken; the block stalls only when a
// second result is ready before the first has been transferred.
//
module battery_voltage_averager #(
   parameter int AVERAGE_LIMIT = 32
) (
   input  logic        clock,
   input  logic        reset,
   bva_req_if.sink     req_chan,
   bva_rsp_if.source   rsp_chan,
   bva_csr_if.sink     csr_chan
);
   import bva_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The threshold register can be written in any cycle.
   assign csr_chan.ready = 1'b1;

   // The controller owns the handshakes and the state; the datapath owns the stored data.
   bva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bva_datapath #(
      .AVERAGE_LIMIT (AVERAGE_LIMIT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_chan.valid && csr_chan.ready),
      .csr_data    (csr_chan.low_threshold_mv),
      .reading_mv  (req_chan.reading_mv),
      .cmd         (cmd),
      .status      (status),
      .average_mv  (rsp_chan.average_mv),
      .percent     (rsp_chan.percent),
      .low_battery (rsp_chan.low_battery)
   );

endmodule
`default_nettype wire

[hdl/bva_checker.sv]
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// bva_checker
// Port-level checks on the averager's result channel.
// ----------------------------------------------------------------------------
module bva_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [bva_pkg::DATA_W-1:0]   average_mv,
   input logic [bva_pkg::PCT_W-1:0]    percent,
   input logic                         low_battery
);
   import bva_pkg::*;

   // A result that was not taken stays offered.
   `BVA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

   // No result is offered in the cycle after reset.
   `BVA_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid, "result valid after reset")

   // A low battery result carries no average and no percentage.
   `BVA_ASSERT(a_low_zero, clock, reset, rsp_valid && low_battery |-> average_mv == '0 && percent == '0, "low result with nonzero fields")

   // The percentage never exceeds full charge.
   `BVA_ASSERT(a_pct_range, clock, reset, rsp_valid |-> percent <= PCT_FULL, "percent above full")

endmodule

bind battery_voltage_averager bva_checker u_bva_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .average_mv  (rsp_chan.average_mv),
   .percent     (rsp_chan.percent),
   .low_battery (rsp_chan.low_battery)
);
`default_nettype wire

[sim/battery_voltage_averager_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// battery_voltage_averager_tb
// Self-checking bench for the battery voltage averager. A directed table and
// a long random run of readings go through the request channel. Every
// accepted reading is folded into a local running-average model, and each
// response transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module battery_voltage_averager_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bva_pkg::*;

   localparam int AVERAGE_LIMIT    = 32;
   localparam int SUM_W            = DATA_W + $clog2(AVERAGE_LIMIT);
   localparam int COUNT_W          = $clog2(AVERAGE_LIMIT + 1);
   localparam int HALF_PERIOD      = 4;
   localparam int RESET_CYCLES     = 3;
   // Before a threshold write, and at the end, the bench waits well past the
   // time that a normal reading keeps the block busy, so a trailing zero
   // reading has also cleared the block.
   localparam int DRAIN_CYCLES     = 2 * (SUM_W + 5);
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PRESSURE_ITEMS   = 12;
   localparam int NUM_PHASES       = 8;
   localparam logic [DATA_W-1:0] PCT_STEP_MV = 16'd10;
   localparam logic [DATA_W-1:0] FULL_SCALE  = 16'hFFFF;

   // One response as the block presents it on the result channel.
   typedef struct packed {
      logic [DATA_W-1:0] average_mv;
      logic [PCT_W-1:0]  percent;
      logic              low_battery;
   } reading_result_type;

   typedef enum logic {
      ROW_READING,
      ROW_THRESHOLD
   } row_kind_type;

   // A directed row either sends a reading or writes the threshold. Where the
   // response is obvious, it is typed into the row and used as the expectation.
   typedef struct packed {
      row_kind_type       kind;
      logic [DATA_W-1:0]  value;
      logic               typed;
      reading_result_type result;
   } directed_row_type;

   typedef enum logic [1:0] {
      SEG_STEADY,
      SEG_SPREAD,
      SEG_FULL_SCALE,
      SEG_NOISE
   } segment_kind_type;

   localparam int NUM_ROWS = 23;

   directed_row_type directed_rows [NUM_ROWS] = '{
      // Reset state, default threshold of 1900 mV.
      '{ROW_READING,   16'd0,     1'b0, '0},                       // zero: no response
      '{ROW_READING,   16'd1899,  1'b1, '{16'd0,    7'd0, 1'b1}},  // just below threshold
      '{ROW_READING,   16'd1900,  1'b1, '{16'd1900, 7'd0, 1'b0}},  // first accepted reading
      '{ROW_READING,   16'd2100,  1'b1, '{16'd2000, 7'd0, 1'b0}},  // average lands on 2000
      '{ROW_READING,   16'd4000,  1'b0, '0},
      '{ROW_READING,   16'hFFFF,  1'b0, '0},
      '{ROW_READING,   16'd1,     1'b1, '{16'd0,    7'd0, 1'b1}},
      // A zero threshold lets every nonzero reading through.
      '{ROW_THRESHOLD, 16'd0,     1'b0, '0},
      '{ROW_READING,   16'd1,     1'b0, '0},
      '{ROW_READING,   16'hFFFF,  1'b0, '0},
      '{ROW_READING,   16'd0,     1'b0, '0},                       // zero beats threshold
      // Full-scale threshold: only a full-scale reading is accepted.
      '{ROW_THRESHOLD, 16'hFFFF,  1'b0, '0},
      '{ROW_READING,   16'hFFFE,  1'b1, '{16'd0,    7'd0, 1'b1}},
      '{ROW_READING,   16'hFFFF,  1'b0, '0},
      '{ROW_READING,   16'h8000,  1'b1, '{16'd0,    7'd0, 1'b1}},
      // Threshold at the bottom of the charge scale.
      '{ROW_THRESHOLD, 16'd2000,  1'b0, '0},
      '{ROW_READING,   16'd1999,  1'b1, '{16'd0,    7'd0, 1'b1}},
      '{ROW_READING,   16'd2000,  1'b0, '0},
      '{ROW_READING,   16'd3000,  1'b0, '0},
      '{ROW_READING,   16'h5555,  1'b0, '0},
      '{ROW_READING,   16'hAAAA,  1'b0, '0},
      '{ROW_READING,   16'd2999,  1'b0, '0},
      '{ROW_THRESHOLD, THRESHOLD_RESET, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset;

   bva_req_if req_chan ();
   bva_rsp_if rsp_chan ();
   bva_csr_if csr_chan ();

   battery_voltage_averager #(
      .AVERAGE_LIMIT(AVERAGE_LIMIT)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   // Local copy of the block's state and its one register.
   logic [DATA_W-1:0]  threshold_mv;
   logic [SUM_W-1:0]   reading_sum;
   logic [COUNT_W-1:0] reading_count;

   // Predicted responses, oldest first.
   reading_result_type pending_results [$];

   // Handshake between the stimulus and the receiver for the long stall.
   bit long_hold_request = 1'b0;

   // Sender burst shaping.
   int burst_left     = 0;
   bit gaps_enabled   = 1'b1;
   int phase_readings = 0;

   // Run statistics and the failure count.
   int readings_accepted = 0;
   int zero_readings     = 0;
   int low_readings      = 0;
   int decay_halvings    = 0;
   int threshold_writes  = 0;
   int results_checked   = 0;
   int fail_count        = 0;

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // Folds one accepted reading into the local state. Returns 1 when the
   // reading produces a response, and the response itself through res.
   // The average is taken before the halving decay, as the block does.
   function automatic bit fold_reading(input logic [DATA_W-1:0] mv,
                                       output reading_result_type res);
      logic [SUM_W-1:0]  avg_wide;
      logic [DATA_W-1:0] avg;
      res = '0;
      if (mv == '0) begin
         zero_readings++;
         return 1'b0;
      end
      if (mv < threshold_mv) begin
         // Low battery: flag only, the running state is left alone.
         low_readings++;
         res.low_battery = 1'b1;
         return 1'b1;
      end
      reading_sum   = reading_sum + SUM_W'(mv);
      reading_count = reading_count + 1'b1;
      avg_wide      = reading_sum / SUM_W'(reading_count);
      avg           = avg_wide[DATA_W-1:0];
      if (reading_count >= COUNT_W'(AVERAGE_LIMIT)) begin
         reading_sum   = reading_sum >> 1;
         reading_count = reading_count >> 1;
         decay_halvings++;
      end
      res.average_mv = avg;
      if (avg >= PCT_HIGH_MV) begin
         res.percent = PCT_FULL;
      end else if (avg > PCT_LOW_MV) begin
         res.percent = PCT_W'((avg - PCT_LOW_MV) / PCT_STEP_MV);
      end else begin
         res.percent = '0;
      end
      return 1'b1;
   endfunction

   // Offers one reading and holds it until the block takes it. Called at a
   // falling edge and returns at a falling edge. A typed result replaces the
   // prediction as the expectation, but the state is always folded.
   task automatic transfer_reading(input logic [DATA_W-1:0] mv, input bit typed,
                                   input reading_result_type typed_res);
      reading_result_type res;
      bit                 produces;
      req_chan.valid      <= 1'b1;
      req_chan.reading_mv <= mv;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      readings_accepted++;
      produces = fold_reading(mv, res);
      if (produces) begin
         pending_results.push_back(typed ? typed_res : res);
      end
      if (mv != '0) begin
         phase_readings++;
      end
      @(negedge clock);
   endtask

   // Sends a reading inside the current burst; when the burst runs out, it may
   // open a gap of random length if gaps are enabled.
   task automatic offer_reading(input logic [DATA_W-1:0] mv, input bit typed,
                                input reading_result_type typed_res);
      int gap;
      transfer_reading(mv, typed, typed_res);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gaps_enabled && gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Drops valid and waits until every predicted response has been seen.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // The threshold is only written with the block idle.
   task automatic write_threshold(input logic [DATA_W-1:0] value);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_chan.valid            <= 1'b1;
      csr_chan.low_threshold_mv <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      threshold_mv = value;
      threshold_writes++;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // A reading that is certain to pass the current threshold.
   function automatic logic [DATA_W-1:0] pick_normal();
      int floor_mv;
      floor_mv = (threshold_mv == '0) ? 1 : int'(threshold_mv);
      return DATA_W'($urandom_range(floor_mv, 65535));
   endfunction

   // One stretch of random readings. Steady runs let the average settle on
   // an exact level, most often within or just beyond the charge scale; full
   // scale runs push the sum to its largest values; noise mixes in zero
   // and low readings.
   task automatic run_segment();
      segment_kind_type  seg;
      logic [DATA_W-1:0] level;
      logic [DATA_W-1:0] mv;
      int                pick;
      int                run_len;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         seg = SEG_STEADY;
      end else if (pick < 7) begin
         seg = SEG_SPREAD;
      end else if (pick < 8) begin
         seg = SEG_FULL_SCALE;
      end else begin
         seg = SEG_NOISE;
      end
      level = ($urandom_range(0, 3) != 0) ? DATA_W'($urandom_range(1990, 3010))
                                           : DATA_W'($urandom_range(1, 65535));
      case (seg)
         SEG_STEADY:     run_len = $urandom_range(20, 45);
         SEG_SPREAD:     run_len = $urandom_range(5, 20);
         SEG_FULL_SCALE: run_len = $urandom_range(10, 40);
         default:        run_len = $urandom_range(3, 10);
      endcase
      repeat (run_len) begin
         case (seg)
            SEG_STEADY: begin
               mv = ($urandom_range(0, 15) == 0) ? '0 : level;
            end
            SEG_SPREAD: begin
               mv = DATA_W'($urandom());
            end
            SEG_FULL_SCALE: begin
               mv = ($urandom_range(0, 7) == 0) ? FULL_SCALE - 1'b1 : FULL_SCALE;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: mv = '0;
                  1: mv = (threshold_mv > 16'd1)
                          ? DATA_W'($urandom_range(1, int'(threshold_mv) - 1))
                          : DATA_W'($urandom_range(1, 255));
                  2: mv = DATA_W'($urandom());
                  default: mv = DATA_W'($urandom_range(1, 255));
               endcase
            end
         endcase
         offer_reading(mv, 1'b0, '0);
      end
   endtask

   // Main stimulus: reset, the directed table, then random phases, each with
   // its own threshold setting.
   initial begin : stimulus
      logic [DATA_W-1:0] phase_threshold [NUM_PHASES];
      int                phase_target    [NUM_PHASES];
      directed_row_type  row;
      bit                long_hold_done;
      bit                quiet_done;

      req_chan.valid            = 1'b0;
      req_chan.reading_mv       = '0;
      csr_chan.valid            = 1'b0;
      csr_chan.low_threshold_mv = '0;
      reset                     = 1'b1;
      long_hold_done            = 1'b0;
      quiet_done                = 1'b0;

      threshold_mv  = THRESHOLD_RESET;
      reading_sum   = '0;
      reading_count = '0;

      // Phase settings: the reset value, both extremes of the register, one,
      // the middle and top of the charge scale and one random value.
      phase_threshold = '{THRESHOLD_RESET, 16'd0, 16'd2500, 16'd1, 16'd3000,
                          DATA_W'($urandom()), FULL_SCALE, THRESHOLD_RESET};
      phase_target    = '{220, 220, 200, 200, 200, 180, 40, 140};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_THRESHOLD) begin
            write_threshold(row.value);
         end else begin
            offer_reading(row.value, row.typed, row.result);
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         write_threshold(phase_threshold[phase]);
         phase_readings = 0;
         // Every other phase runs with the sender never idling.
         gaps_enabled = (phase % 2 == 0);
         while (phase_readings < phase_target[phase]) begin
            run_segment();
            if (phase == 0 && !long_hold_done && phase_readings >= 100) begin
               // The receiver holds off for a long stretch while the sender
               // keeps offering accepted readings, so the output register and
               // the datapath both fill and the request channel stalls.
               long_hold_done    = 1'b1;
               long_hold_request = 1'b1;
               repeat (PRESSURE_ITEMS) transfer_reading(pick_normal(), 1'b0, '0);
            end
            if (phase == 3 && !quiet_done && phase_readings >= 100) begin
               // The sender goes quiet until every response is back.
               quiet_done = 1'b1;
               wait_for_results();
            end
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run covered %0d readings (%0d zero, %0d low) and %0d checked responses,",
               readings_accepted, zero_readings, low_readings, results_checked);
      $display("with %0d decay halvings across %0d threshold writes.",
               decay_halvings, threshold_writes);
      if (fail_count == 0) begin
         $display("** battery_voltage_averager: PASSED **");
      end else begin
         $display("** battery_voltage_averager: FAILED **");
      end
      $finish;
   end

   // Receiver: ready follows a rotating sixteen-bit pattern that is replaced after
   // a random stretch. Patterns range from always ready to a single ready bit.
   // On request it holds ready low for a long, counted stretch.
   initial begin : receiver
      logic [15:0] ready_pattern;
      int          pattern_cycles;
      ready_pattern  = '1;
      pattern_cycles = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold_request = 1'b0;
         end else begin
            if (pattern_cycles == 0) begin
               case ($urandom_range(0, 3))
                  0:       ready_pattern = '1;
                  1:       ready_pattern = 16'($urandom()) | 16'h0001;
                  2:       ready_pattern = 16'h0001 << $urandom_range(0, 15);
                  default: ready_pattern = 16'hAAAA;
               endcase
               pattern_cycles = $urandom_range(16, 96);
            end
            pattern_cycles--;
            rsp_chan.ready <= ready_pattern[0];
            ready_pattern   = {ready_pattern[0], ready_pattern[15:1]};
         end
      end
   end

   // Response checker: every transfer is matched against the oldest
   // prediction. The fields are compared one at a time.
   always @(posedge clock) begin : result_check
      reading_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response: average_mv %0d, percent %0d, low_battery %0b",
                   rsp_chan.average_mv, rsp_chan.percent, rsp_chan.low_battery);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_chan.average_mv !== want.average_mv) begin
               $error("average_mv: expected %0d, got %0d",
                      want.average_mv, rsp_chan.average_mv);
               fail_count++;
            end
            if (rsp_chan.percent !== want.percent) begin
               $error("percent: expected %0d, got %0d", want.percent, rsp_chan.percent);
               fail_count++;
            end
            if (rsp_chan.low_battery !== want.low_battery) begin
               $error("low_battery: expected %0b, got %0b",
                      want.low_battery, rsp_chan.low_battery);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #8_000_000;
      $display("Timeout with %0d responses still outstanding.", pending_results.size());
      $display("** battery_voltage_averager: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire
